// ===== src/sac_pkg.sv =====
// Shared types and constants for the set-associative cache hit/miss classifier.
// Used by the controller, the datapath, the divider and the top level.
package sac_pkg;

  localparam int ADDR_W       = 31;
  localparam int ENT_W        = 12;
  localparam int WAYS_W       = 4;
  localparam int CFG_IDX_W    = 1;
  localparam int STEP_W       = 5;
  localparam int DEF_MAX_SETS = 256;
  localparam int DEF_MAX_WAYS = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS    = 1'b1;

  localparam logic [ENT_W-1:0]  ENTRIES_RESET = 12'd8;
  localparam logic [WAYS_W-1:0] WAYS_RESET    = 4'd1;

  localparam logic [STEP_W-1:0] SETS_STEPS = STEP_W'(ENT_W);
  localparam logic [STEP_W-1:0] TAG_STEPS  = STEP_W'(ADDR_W);

  typedef struct packed {
    logic clear_wr;
    logic load_in;
    logic start_sets;
    logic take_sets;
    logic start_tag;
    logic take_tag;
    logic rd;
    logic check;
    logic next_way;
    logic fill;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_busy;
    logic match;
    logic last_way;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/sac_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package needed.
module sac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sac_div.sv =====
// Restoring divider, one quotient bit per cycle, for the set count and the tag.
// Depends on sac_pkg for the address, entries and step counter widths.
module sac_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sac_pkg::ADDR_W-1:0] dividend,
  input  logic [sac_pkg::STEP_W-1:0] steps,
  input  logic [sac_pkg::ENT_W-1:0]  divisor,
  output logic                       busy,
  output logic [sac_pkg::ADDR_W-1:0] quotient,
  output logic [sac_pkg::ENT_W-1:0]  remainder
);
  import sac_pkg::*;

  logic [STEP_W-1:0] count;
  logic [ADDR_W-1:0] quo;
  logic [ENT_W-1:0]  rem;
  logic [ENT_W-1:0]  dvs;
  logic [ENT_W:0]    shifted;
  logic [ENT_W:0]    diff;
  logic              ge;

  assign shifted = {rem, quo[ADDR_W-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= steps;
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[ADDR_W-2:0], ge};
      rem <= ge ? diff[ENT_W-1:0] : shifted[ENT_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== src/sac_ctrl.sv =====
// Sequencing state machine: clearing pass, divisions, way probes, fill, result.
// Depends on sac_pkg for the command and status structs.
module sac_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output sac_pkg::dp_cmd_t    cmd,
  input  sac_pkg::dp_status_t status
);
  import sac_pkg::*;

  localparam logic [3:0] ST_CLEAR     = 4'd0;
  localparam logic [3:0] ST_IDLE      = 4'd1;
  localparam logic [3:0] ST_SETS      = 4'd2;
  localparam logic [3:0] ST_SETS_WAIT = 4'd3;
  localparam logic [3:0] ST_TAG       = 4'd4;
  localparam logic [3:0] ST_TAG_WAIT  = 4'd5;
  localparam logic [3:0] ST_READ      = 4'd6;
  localparam logic [3:0] ST_CHECK     = 4'd7;
  localparam logic [3:0] ST_FILL      = 4'd8;
  localparam logic [3:0] ST_DONE      = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_SETS;
        end
      end
      ST_SETS: begin
        cmd.start_sets = 1'b1;
        state_next     = ST_SETS_WAIT;
      end
      ST_SETS_WAIT: begin
        if (!status.div_busy) begin
          cmd.take_sets = 1'b1;
          state_next    = ST_TAG;
        end
      end
      ST_TAG: begin
        cmd.start_tag = 1'b1;
        state_next    = ST_TAG_WAIT;
      end
      ST_TAG_WAIT: begin
        if (!status.div_busy) begin
          cmd.take_tag = 1'b1;
          state_next   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (status.match) begin
          state_next = ST_DONE;
        end else if (status.last_way) begin
          state_next = ST_FILL;
        end else begin
          cmd.next_way = 1'b1;
          state_next   = ST_READ;
        end
      end
      ST_FILL: begin
        cmd.fill   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== src/sac_datapath.sv =====
// Configuration registers, set and tag split, line store, way probing and result register.
// Depends on sac_pkg, sac_div and sac_ram.
module sac_datapath #(
  parameter int MAX_SETS = sac_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = sac_pkg::DEF_MAX_WAYS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sac_pkg::ENT_W-1:0]     cfg_data,
  input  logic [sac_pkg::ADDR_W-1:0]    word_address,
  output logic [sac_pkg::ADDR_W-1:0]    echo_address,
  output logic                          is_hit,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  sac_pkg::dp_cmd_t              cmd,
  output sac_pkg::dp_status_t           status
);
  import sac_pkg::*;

  localparam int LINES = MAX_SETS * MAX_WAYS;
  localparam int LW    = (LINES > 1) ? $clog2(LINES) : 1;

  logic [ENT_W-1:0]        entries;
  logic [WAYS_W-1:0]       ways_cfg;
  logic [WAYS_W-1:0]       ways_eff;
  logic [ENT_W-1:0]        ent_clamp;
  logic [ADDR_W-1:0]       addr;
  logic [WAYS_W-1:0]       ways;
  logic [ENT_W-1:0]        sets;
  logic [ADDR_W-1:0]       tag;
  logic [LW-1:0]           base;
  logic [WAYS_W-1:0]       way;
  logic                    inv_found;
  logic [WAYS_W-1:0]       inv_way;
  logic                    hit;
  logic [LW-1:0]           clr;
  logic                    div_start;
  logic [ADDR_W-1:0]       div_dividend;
  logic [STEP_W-1:0]       div_steps;
  logic [ENT_W-1:0]        div_divisor;
  logic                    div_busy;
  logic [ADDR_W-1:0]       quo;
  logic [ENT_W-1:0]        rem;
  logic [ENT_W+WAYS_W-1:0] prod;
  logic                    ram_we;
  logic [LW-1:0]           ram_waddr;
  logic [ADDR_W:0]         ram_wdata;
  logic [LW-1:0]           ram_raddr;
  logic [ADDR_W:0]         ram_rdata;
  logic [LW-1:0]           fill_idx;
  logic                    line_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries  <= ENTRIES_RESET;
      ways_cfg <= WAYS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENTRIES: entries  <= cfg_data;
        REG_WAYS:    ways_cfg <= cfg_data[WAYS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (ways_cfg == '0) begin
      ways_eff = WAYS_W'(1);
    end else if (32'(ways_cfg) > MAX_WAYS) begin
      ways_eff = WAYS_W'(MAX_WAYS);
    end else begin
      ways_eff = ways_cfg;
    end
  end

  // Clamping the dividend to the line count also caps the set count.
  assign ent_clamp = (32'(entries) > LINES) ? ENT_W'(LINES) : entries;

  assign div_start    = cmd.start_sets | cmd.start_tag;
  assign div_dividend = cmd.start_sets ? {ent_clamp, {(ADDR_W-ENT_W){1'b0}}} : addr;
  assign div_steps    = cmd.start_sets ? SETS_STEPS : TAG_STEPS;
  assign div_divisor  = cmd.start_sets ? ENT_W'(ways) : sets;

  sac_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .steps     (div_steps),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (quo),
    .remainder (rem)
  );

  assign prod = rem * ways;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      addr <= word_address;
      ways <= ways_eff;
    end
    if (cmd.take_sets) begin
      sets <= (quo[ENT_W-1:0] == '0) ? ENT_W'(1) : quo[ENT_W-1:0];
    end
    if (cmd.take_tag) begin
      tag       <= quo;
      base      <= prod[LW-1:0];
      way       <= '0;
      inv_found <= 1'b0;
      hit       <= 1'b0;
    end
    if (cmd.check) begin
      if (status.match) begin
        hit <= 1'b1;
      end else if (!line_ok && !inv_found) begin
        inv_found <= 1'b1;
        inv_way   <= way;
      end
    end
    if (cmd.next_way) begin
      way <= way + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clear_wr) begin
      clr <= clr + 1'b1;
    end
  end

  assign fill_idx  = base + (inv_found ? LW'(inv_way) : LW'(0));
  assign ram_we    = cmd.clear_wr | cmd.fill;
  assign ram_waddr = cmd.clear_wr ? clr : fill_idx;
  assign ram_wdata = cmd.clear_wr ? '0 : {1'b1, tag};
  assign ram_raddr = base + LW'(way);

  sac_ram #(
    .WIDTH (ADDR_W + 1),
    .DEPTH (LINES)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign line_ok = ram_rdata[ADDR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      echo_address <= addr;
      is_hit       <= hit;
    end
  end

  assign status.clear_last = (clr == LW'(LINES - 1));
  assign status.div_busy   = div_busy;
  assign status.match      = line_ok && (ram_rdata[ADDR_W-1:0] == tag);
  assign status.last_way   = (way == ways - 1'b1);
  assign status.out_free   = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("Result register loaded while a result is still pending.");

  a_fill_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    cmd.fill |-> !hit)
    else $error("Line filled although the request hit.");

  a_div_starts: assert property (@(posedge clk) disable iff (rst)
    div_start |=> div_busy)
    else $error("Divider did not start after a start command.");

  a_way_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.check |-> (way < ways))
    else $error("Way probe beyond the ways in use.");
`endif

endmodule

// ===== src/set_assoc_cache_hit_miss.sv =====
// Set-associative cache hit/miss classifier, top level.
// Depends on sac_pkg, sac_ctrl and sac_datapath.
//
// Requests arrive on in_valid/in_ready with one word address each; every
// request gives exactly one result on out_valid/out_ready carrying the same
// address and a hit flag. The set count is entries_in_use / ways_in_use
// (saturated to at least one set and to the size of the line store); the
// set is the address modulo the set count and the tag the quotient. On a
// miss the lowest invalid way is filled, or way 0 when the set is full.
// A request goes from acceptance to the result register through the divider,
// a store read and a compare for each way probed (the hit way, or all ways
// in use on a miss), and a fill on a miss. The bit-serial divider takes
// 12 steps for the set count and 31 for the tag, each with a start and a
// hand-over state. One request is worked on at a time; the next one is
// accepted only once the controller is back in its idle state.
// After reset the line store is cleared at one line per cycle, all
// MAX_SETS * MAX_WAYS lines (2048 by default), before in_ready rises;
// configuration writes are taken throughout. A held result does not stop
// the next request being accepted and processed; it waits in its final
// step until the result register is free.
module set_assoc_cache_hit_miss #(
  parameter int MAX_SETS = sac_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = sac_pkg::DEF_MAX_WAYS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sac_pkg::ENT_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sac_pkg::ADDR_W-1:0]    word_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sac_pkg::ADDR_W-1:0]    echo_address,
  output logic                          is_hit
);
  import sac_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  sac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  sac_datapath #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .word_address (word_address),
    .echo_address (echo_address),
    .is_hit       (is_hit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for set_assoc_cache_hit_miss: a directed table, then random
// address streams under ten cache geometries, idling on both channels in the first seven.
// Depends on sac_pkg and the RTL under src; it keeps its own model of the line store.
module testbench;
  import sac_pkg::*;

  localparam int LINES = DEF_MAX_SETS * DEF_MAX_WAYS;
  localparam int PHASES = 10;
  localparam int PHASE_LOOKUPS = 85;
  localparam int PLAN_ROWS = 32;

  typedef enum logic {ROW_WRITE, ROW_LOOKUP} row_kind_t;
  typedef enum logic [1:0] {OUTCOME_PREDICT, OUTCOME_MISS, OUTCOME_HIT} row_outcome_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    index;
    logic [ADDR_W-1:0]       value;
    row_outcome_t            outcome;
  } plan_row_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              hit;
  } lookup_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ENT_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [ADDR_W-1:0]    word_address;
  logic                 out_valid;
  logic                 out_ready;
  logic [ADDR_W-1:0]    echo_address;
  logic                 is_hit;

  // Model of the cache: line store and the two geometry registers.
  logic              line_held [LINES];
  logic [ADDR_W-1:0] line_tag_store [LINES];
  logic [ENT_W-1:0]  model_entries;
  logic [WAYS_W-1:0] model_ways;

  lookup_t           pending_lookups [$];
  logic [ADDR_W-1:0] recent_addresses [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  int unsigned mismatches;
  int unsigned hits_seen;
  int unsigned misses_seen;
  int unsigned geometries;

  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{ROW_LOOKUP, REG_ENTRIES, 31'h0000_0000, OUTCOME_MISS},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h0000_0000, OUTCOME_HIT},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h0000_0008, OUTCOME_MISS},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h0000_0000, OUTCOME_MISS},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h7FFF_FFFF, OUTCOME_MISS},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h7FFF_FFFF, OUTCOME_HIT},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h7FFF_FFF7, OUTCOME_MISS},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h2AAA_AAAA, OUTCOME_MISS},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h5555_5555, OUTCOME_MISS},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h2AAA_AAAA, OUTCOME_HIT},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h5555_5555, OUTCOME_HIT},
    '{ROW_WRITE,  REG_WAYS,    31'h0000_0000, OUTCOME_PREDICT},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h0000_0000, OUTCOME_PREDICT},
    '{ROW_WRITE,  REG_WAYS,    31'h0000_0FFF, OUTCOME_PREDICT},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h0000_0000, OUTCOME_PREDICT},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h0000_0001, OUTCOME_PREDICT},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h0000_0002, OUTCOME_PREDICT},
    '{ROW_WRITE,  REG_ENTRIES, 31'h0000_0003, OUTCOME_PREDICT},
    '{ROW_WRITE,  REG_WAYS,    31'h0000_0004, OUTCOME_PREDICT},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h0000_0001, OUTCOME_PREDICT},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h0000_0002, OUTCOME_PREDICT},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h0000_0003, OUTCOME_PREDICT},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h0000_0004, OUTCOME_PREDICT},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h0000_0005, OUTCOME_PREDICT},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h0000_0001, OUTCOME_PREDICT},
    '{ROW_WRITE,  REG_ENTRIES, 31'h0000_0FFF, OUTCOME_PREDICT},
    '{ROW_WRITE,  REG_WAYS,    31'h0000_0001, OUTCOME_PREDICT},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h0000_07FF, OUTCOME_PREDICT},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h7FFF_FFFF, OUTCOME_PREDICT},
    '{ROW_WRITE,  REG_ENTRIES, 31'h0000_0000, OUTCOME_PREDICT},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h1234_5678, OUTCOME_PREDICT},
    '{ROW_LOOKUP, REG_ENTRIES, 31'h1234_5678, OUTCOME_HIT}
  };

  int unsigned phase_entries [PHASES] = '{16, 4095, 1, 64, 4095, 2, 100, 2048, 4095, 37};
  int unsigned phase_ways [PHASES]    = '{2, 8, 1, 4, 15, 3, 0, 5, 1, 7};

  set_assoc_cache_hit_miss dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .word_address (word_address),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .echo_address (echo_address),
    .is_hit       (is_hit)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned way_count();
    int unsigned w;
    w = model_ways;
    if (w == 0) w = 1;
    if (w > DEF_MAX_WAYS) w = DEF_MAX_WAYS;
    return w;
  endfunction

  function automatic int unsigned set_count(input int unsigned ways);
    int unsigned s;
    s = model_entries / ways;
    if (s == 0) s = 1;
    if (s > LINES / ways) s = LINES / ways;
    return s;
  endfunction

  // Looks the address up in the model store and applies the fill on a miss.
  function automatic logic classify_and_fill(input logic [ADDR_W-1:0] address);
    int unsigned ways, sets, base, w;
    logic [ADDR_W-1:0] tag;
    ways = way_count();
    sets = set_count(ways);
    base = (address % sets) * ways;
    tag  = ADDR_W'(address / sets);
    for (w = 0; w < ways; w++) begin
      if (line_held[base + w] && line_tag_store[base + w] == tag) return 1'b1;
    end
    for (w = 0; w < ways; w++) begin
      if (!line_held[base + w]) begin
        line_held[base + w] = 1'b1;
        line_tag_store[base + w] = tag;
        return 1'b0;
      end
    end
    line_tag_store[base] = tag;
    return 1'b0;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned roll, sets;
    logic [ADDR_W-1:0] address;
    roll = $urandom_range(99);
    sets = set_count(way_count());
    if (recent_addresses.size() == 0 || roll < 10) begin
      address = ADDR_W'($urandom);
    end else if (roll < 50) begin
      address = recent_addresses[$urandom_range(recent_addresses.size() - 1)];
    end else if (roll < 80) begin
      address = recent_addresses[$urandom_range(recent_addresses.size() - 1)]
                + ADDR_W'(sets * $urandom_range(1, 9));
    end else begin
      address = ADDR_W'($urandom_range(0, 16 * sets));
    end
    return address;
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [ENT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    if (index == REG_ENTRIES) model_entries = data;
    else model_ways = data[WAYS_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for every outstanding result, then a short margin before the next register write.
  task automatic wait_for_idle();
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_request(input logic [ADDR_W-1:0] address, input row_outcome_t outcome);
    int unsigned gap;
    lookup_t entry;
    logic predicted;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    word_address <= address;
    do @(posedge clk); while (!in_ready);
    predicted = classify_and_fill(address);
    entry.address = address;
    if (outcome == OUTCOME_HIT) entry.hit = 1'b1;
    else if (outcome == OUTCOME_MISS) entry.hit = 1'b0;
    else entry.hit = predicted;
    pending_lookups.push_back(entry);
    recent_addresses.push_back(address);
    if (recent_addresses.size() > 32) void'(recent_addresses.pop_front());
  endtask

  // Result side: checks each accepted result and sets out_ready for the next cycle.
  initial begin
    lookup_t want;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_lookups.size() == 0) begin
          $display("%0t: result with no request outstanding: address %h hit %b",
                   $time, echo_address, is_hit);
          mismatches++;
        end else begin
          want = pending_lookups.pop_front();
          if (echo_address !== want.address) begin
            $display("%0t: echo_address expected %h actual %h", $time, want.address,
                     echo_address);
            mismatches++;
          end
          if (is_hit !== want.hit) begin
            $display("%0t: is_hit for %h expected %b actual %b", $time, want.address,
                     want.hit, is_hit);
            mismatches++;
          end
          if (want.hit) hits_seen++;
          else misses_seen++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("set_assoc_cache_hit_miss regression: fail");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_ENTRIES;
    cfg_data      = '0;
    in_valid      = 1'b0;
    word_address  = '0;
    send_idle_pct = 32;
    recv_idle_pct = 87;
    hold_left     = 0;
    mismatches    = 0;
    hits_seen     = 0;
    misses_seen   = 0;
    geometries    = 1;
    model_entries = ENTRIES_RESET;
    model_ways    = WAYS_RESET;
    for (int i = 0; i < LINES; i++) begin
      line_held[i] = 1'b0;
      line_tag_store[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (directed_plan[r].kind == ROW_WRITE) begin
        in_valid <= 1'b0;
        wait_for_idle();
        write_register(directed_plan[r].index, directed_plan[r].value[ENT_W-1:0]);
        geometries++;
      end else begin
        send_request(directed_plan[r].value, directed_plan[r].outcome);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      wait_for_idle();
      case (p * 3 / PHASES)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_register(REG_ENTRIES, ENT_W'(phase_entries[p]));
      write_register(REG_WAYS, ENT_W'(phase_ways[p]));
      geometries++;
      for (int n = 0; n < PHASE_LOOKUPS; n++) begin
        // A long stall on the result side lets the block back up into its request side.
        if (p == 0 && n == 20) hold_left = 600;
        send_request(pick_address(), OUTCOME_PREDICT);
      end
    end
    in_valid <= 1'b0;

    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Checked %0d lookups (%0d hits, %0d misses) across %0d cache geometries,",
             hits_seen + misses_seen, hits_seen, misses_seen, geometries);
    $display("including zero and oversized way counts, one-set and capped set counts.");
    if (mismatches == 0) begin
      $display("set_assoc_cache_hit_miss regression: pass");
    end else begin
      $display("set_assoc_cache_hit_miss regression: fail");
    end
    $finish;
  end

endmodule
